// File: hdl/spa_pkg.sv
package spa_pkg;

	localparam int MAX_TERMS = 16;
	localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);

	localparam logic [1:0] ACT_ADD_FIRST  = 2'd0;
	localparam logic [1:0] ACT_ADD_SECOND = 2'd1;
	localparam logic [1:0] ACT_SUM        = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] coefficient;
		logic signed [15:0] exponent;
	} cmd_t;

	typedef struct packed {
		logic signed [32:0] sum_coefficient;
		logic signed [15:0] sum_exponent;
		logic               last;
		logic               empty_res;
		logic               dropped;
	} result_t;

	typedef struct packed {
		logic signed [31:0] coefficient;
		logic signed [15:0] exponent;
	} term_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		term_t            data;
	} tbl_wr_t;

	typedef struct packed {
		logic signed [15:0] exp_x;
		logic signed [15:0] exp_y;
		logic signed [31:0] coef_x;
		logic signed [31:0] coef_y;
	} cmp_op_t;

	typedef struct packed {
		logic               gt;
		logic               eq;
		logic signed [32:0] sum;
	} cmp_res_t;

endpackage

// File: hdl/sparse_polynomial_adder_unit.sv
// Channel   Ports                       Transfer
// command   start, cmd (cmd_t)          start high while busy low
// result    result_valid, result        one cycle per result, always taken
//
// Adding a term walks down its table from the end, moving one entry per
// read and compare step through the table and the shared compare unit.
// A full table drops the term. Each result term of a sum takes a table
// read, then a compare/add. An empty sum answers in the cycle after its
// command. Reset clears counts and the drop flag.
// busy is high while a term is being placed or a sum is being merged.
module sparse_polynomial_adder_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  spa_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             result_valid,
	output spa_pkg::result_t result
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_RD  = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_MRG_RD  = 3'd3;
	localparam logic [2:0] S_MRG_CMP = 3'd4;

	logic [2:0]                state_q;
	logic [spa_pkg::CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic [spa_pkg::CNT_W-1:0] i_q, a_q, b_q;
	logic                      sel_q;
	logic                      drop_q;
	spa_pkg::term_t            nt_q;
	logic                      res_valid_q;
	spa_pkg::result_t          res_q;
	spa_pkg::result_t          res_d;

	spa_pkg::tbl_wr_t          wr_a, wr_b, wr;
	logic [spa_pkg::IDX_W-1:0] raddr_a, raddr_b;
	spa_pkg::term_t            rd_a, rd_b, rd_sel;
	spa_pkg::cmp_op_t          op;
	spa_pkg::cmp_res_t         cr;

	logic                      accept;
	logic                      a_ok, b_ok, take_both, take_a;
	logic [spa_pkg::CNT_W-1:0] a_nx, b_nx, i_dec;
	logic                      mrg_last;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign i_dec  = i_q - spa_pkg::CNT_W'(1);

	spa_table u_tbl_a (.clk(clk), .wr(wr_a), .raddr(raddr_a), .rdata(rd_a));
	spa_table u_tbl_b (.clk(clk), .wr(wr_b), .raddr(raddr_b), .rdata(rd_b));
	spa_cmp   u_cmp   (.op(op), .res(cr));

	assign rd_sel  = sel_q ? rd_b : rd_a;
	assign raddr_a = (state_q == S_MRG_RD) ? a_q[spa_pkg::IDX_W-1:0]
	                                       : i_dec[spa_pkg::IDX_W-1:0];
	assign raddr_b = (state_q == S_MRG_RD) ? b_q[spa_pkg::IDX_W-1:0]
	                                       : i_dec[spa_pkg::IDX_W-1:0];

	always_comb begin
		op.coef_x = rd_a.coefficient;
		op.coef_y = rd_b.coefficient;
		if (state_q == S_INS_CMP) begin
			op.exp_x = nt_q.exponent;
			op.exp_y = rd_sel.exponent;
		end else begin
			op.exp_x = rd_a.exponent;
			op.exp_y = rd_b.exponent;
		end
	end

	// Insertion write port: move the smaller entry up one slot, or drop the new term in.
	always_comb begin
		wr.we   = 1'b0;
		wr.addr = i_q[spa_pkg::IDX_W-1:0];
		wr.data = nt_q;
		case (state_q)
			S_INS_RD: begin
				wr.we = (i_q == '0);
			end
			S_INS_CMP: begin
				wr.we = 1'b1;
				if (cr.gt) begin
					wr.data = rd_sel;
				end
			end
			default: begin
				wr.we = 1'b0;
			end
		endcase
		wr_a    = wr;
		wr_b    = wr;
		wr_a.we = wr.we && !sel_q;
		wr_b.we = wr.we && sel_q;
	end

	// Merge selection
	always_comb begin
		a_ok      = (a_q != cnt_a_q);
		b_ok      = (b_q != cnt_b_q);
		take_both = a_ok && b_ok && cr.eq;
		take_a    = !take_both && (!b_ok || (a_ok && cr.gt));
		a_nx      = (take_both || take_a) ? a_q + spa_pkg::CNT_W'(1) : a_q;
		b_nx      = (take_both || !take_a) ? b_q + spa_pkg::CNT_W'(1) : b_q;
		mrg_last  = (a_nx == cnt_a_q) && (b_nx == cnt_b_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			drop_q      <= 1'b0;
			res_valid_q <= 1'b0;
			i_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			sel_q       <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.action)
							spa_pkg::ACT_ADD_FIRST, spa_pkg::ACT_ADD_SECOND: begin
								sel_q <= (cmd.action == spa_pkg::ACT_ADD_SECOND);
								if (cmd.action == spa_pkg::ACT_ADD_SECOND) begin
									i_q <= cnt_b_q;
								end else begin
									i_q <= cnt_a_q;
								end
								if ((cmd.action == spa_pkg::ACT_ADD_SECOND &&
								     cnt_b_q == spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) ||
								    (cmd.action == spa_pkg::ACT_ADD_FIRST &&
								     cnt_a_q == spa_pkg::CNT_W'(spa_pkg::MAX_TERMS))) begin
									drop_q <= 1'b1;
								end else begin
									state_q <= S_INS_RD;
								end
							end
							spa_pkg::ACT_SUM: begin
								a_q <= '0;
								b_q <= '0;
								if (cnt_a_q == '0 && cnt_b_q == '0) begin
									res_valid_q <= 1'b1;
									drop_q      <= 1'b0;
								end else begin
									state_q <= S_MRG_RD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						if (sel_q) cnt_b_q <= cnt_b_q + spa_pkg::CNT_W'(1);
						else       cnt_a_q <= cnt_a_q + spa_pkg::CNT_W'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (cr.gt) begin
						i_q     <= i_dec;
						state_q <= S_INS_RD;
					end else begin
						if (sel_q) cnt_b_q <= cnt_b_q + spa_pkg::CNT_W'(1);
						else       cnt_a_q <= cnt_a_q + spa_pkg::CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_MRG_RD: begin
					state_q <= S_MRG_CMP;
				end
				S_MRG_CMP: begin
					res_valid_q <= 1'b1;
					a_q         <= a_nx;
					b_q         <= b_nx;
					if (mrg_last) begin
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						drop_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MRG_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Build each result term; idle keeps the empty marker ready.
	always_comb begin
		res_d = res_q;
		if (state_q == S_IDLE) begin
			res_d           = '0;
			res_d.empty_res = 1'b1;
		end else if (state_q == S_MRG_CMP) begin
			res_d.last      = mrg_last;
			res_d.empty_res = 1'b0;
			res_d.dropped   = drop_q;
			if (take_both) begin
				res_d.sum_coefficient = cr.sum;
				res_d.sum_exponent    = rd_a.exponent;
			end else if (take_a) begin
				res_d.sum_coefficient = $signed({rd_a.coefficient[31], rd_a.coefficient});
				res_d.sum_exponent    = rd_a.exponent;
			end else begin
				res_d.sum_coefficient = $signed({rd_b.coefficient[31], rd_b.coefficient});
				res_d.sum_exponent    = rd_b.exponent;
			end
		end
	end

	// New term and result payload: hold the new term on accept, register the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			nt_q <= '{coefficient: cmd.coefficient, exponent: cmd.exponent};
		end
		res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: hdl/spa_table.sv
module spa_table (
	input  logic                     clk,
	input  spa_pkg::tbl_wr_t         wr,
	input  logic [spa_pkg::IDX_W-1:0] raddr,
	output spa_pkg::term_t           rdata
);

	spa_pkg::term_t mem_q [spa_pkg::MAX_TERMS];
	spa_pkg::term_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/spa_cmp.sv
module spa_cmp (
	input  spa_pkg::cmp_op_t  op,
	output spa_pkg::cmp_res_t res
);

	always_comb begin
		res.gt  = op.exp_x > op.exp_y;
		res.eq  = op.exp_x == op.exp_y;
		res.sum = $signed({op.coef_x[31], op.coef_x}) + $signed({op.coef_y[31], op.coef_y});
	end

endmodule

// File: hdl/spa_checker.sv
module spa_port_checks (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input spa_pkg::cmd_t    cmd,
	input logic             busy,
	input logic             result_valid,
	input spa_pkg::result_t result
);

	// An empty-sum marker carries nothing else.
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.empty_res |->
			!result.last && !result.dropped &&
			result.sum_coefficient == '0 && result.sum_exponent == '0)
		else $error("empty result carries nonzero fields");

	// More terms follow a non-final merge result, so the unit stays busy.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.empty_res && !result.last |-> busy)
		else $error("unit idle before last merge term");

	// The final term of a sum releases the unit.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("unit busy after last merge term");

	// Loading a term produces no result.
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.action == spa_pkg::ACT_ADD_FIRST ||
		                   cmd.action == spa_pkg::ACT_ADD_SECOND) |=> !result_valid)
		else $error("result after term load");

	// Merge terms come only out of a running merge.
	a_merge_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.empty_res |-> $past(busy))
		else $error("merge result without a running merge");

endmodule

bind sparse_polynomial_adder_unit spa_port_checks u_spa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.cmd          (cmd),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
